@@ src/gmwm_pkg.sv @@
`timescale 1ns / 1ps

package gmwm_pkg;

	// Largest grid side the cell coordinates can address
	localparam logic [4:0] GRID_SIDE = 5'd16;

	// Operation codes of a request beat
	localparam logic OP_WALL = 1'b0;
	localparam logic OP_STEP = 1'b1;

	// Headings and passage directions
	localparam logic [1:0] DIR_N = 2'd0;
	localparam logic [1:0] DIR_E = 2'd1;
	localparam logic [1:0] DIR_S = 2'd2;
	localparam logic [1:0] DIR_W = 2'd3;

	// Register indexes on the configuration port
	localparam logic [1:0] REG_GRID_SIZE = 2'd0;
	localparam logic [1:0] REG_GOAL_X    = 2'd1;
	localparam logic [1:0] REG_GOAL_Y    = 2'd2;

	// Register reset values
	localparam logic [4:0] GRID_SIZE_RST = 5'd9;
	localparam logic [3:0] GOAL_X_RST    = 4'd4;
	localparam logic [3:0] GOAL_Y_RST    = 4'd4;

	// Passage storage: bit 0 north open, bit 1 east open
	localparam logic [1:0] PASSAGE_RST = 2'b11;

	// Where the passage leaving a cell in one direction is stored
	typedef struct packed {
		logic       ok;    // passage lies inside the grid in use
		logic [7:0] addr;  // entry holding the passage bit
		logic       east;  // bit 1 of the entry, else bit 0
		logic [7:0] nbr;   // cell on the far side
	} loc_t;

endpackage

@@ src/gmwm_if.sv @@
`timescale 1ns / 1ps

interface gmwm_req_if;
	logic       valid;
	logic       ready;
	logic       operation;
	logic [7:0] cell_req;
	logic [1:0] heading;
	logic       seen_left;
	logic       seen_front;
	logic       seen_right;

	modport source(
		output valid, operation, cell_req, heading, seen_left, seen_front, seen_right,
		input  ready
	);
	modport sink(
		input  valid, operation, cell_req, heading, seen_left, seen_front, seen_right,
		output ready
	);
endinterface

interface gmwm_rsp_if;
	logic       valid;
	logic       ready;
	logic       changed;
	logic       found;
	logic [7:0] next_cell;

	modport source(
		output valid, changed, found, next_cell,
		input  ready
	);
	modport sink(
		input  valid, changed, found, next_cell,
		output ready
	);
endinterface

@@ src/grid_maze_wall_map_greedy_step.sv @@
`timescale 1ns / 1ps
// A result beat is registered once all four neighbour passages are evaluated;
// a new request is taken only after it is loaded. Each request scans the four
// neighbour passages one per cycle through the single read port of each memory.
// Reset (arst_n low): registers return to grid 9, goal (4,4); after release
// a pass over all 256 entries opens all passages and clears all visited marks.

module grid_maze_wall_map_greedy_step (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	gmwm_req_if.sink          req,
	gmwm_rsp_if.source        rsp
);

	typedef enum logic [3:0] {
		ST_INIT = 4'b0001,
		ST_IDLE = 4'b0010,
		ST_RUN  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	// Configuration registers
	logic [4:0] grid_size_q;
	logic [3:0] goal_x_q;
	logic [3:0] goal_y_q;
	logic [4:0] side;

	// Sequencer and held request
	state_t     state_q;
	logic [7:0] clr_q;
	logic [1:0] k_q;
	logic       op_q;
	logic [3:0] row_q;
	logic [3:0] col_q;
	logic [1:0] hd_q;
	logic       wl_q;
	logic       wf_q;
	logic       wr_q;

	// Running result
	logic       chg_q;
	logic       fnd_q;
	logic [8:0] best_q;
	logic [7:0] nxt_q;
	logic       chg_d;
	logic       fnd_d;
	logic [8:0] best_d;
	logic [7:0] nxt_d;

	// Response register
	logic       rsp_vld_q;
	logic       rsp_chg_q;
	logic       rsp_fnd_q;
	logic [7:0] rsp_nxt_q;
	logic       out_free;
	logic       rsp_load;
	logic       rsp_chg_n;
	logic       rsp_fnd_n;
	logic [7:0] rsp_nxt_n;

	// Memories and read stage
	logic [1:0]   open_mem [256];
	logic         vis_mem  [256];
	logic [1:0]   open_rd_s1;
	logic         vis_rd_s1;
	logic         fwd_hit_s1;
	logic [1:0]   fwd_data_s1;

	// Read issue
	logic [3:0]     rd_row;
	logic [3:0]     rd_col;
	logic [1:0]     rd_k;
	gmwm_pkg::loc_t rd_loc;

	// Evaluation
	gmwm_pkg::loc_t cur;
	logic [1:0]     cur_dir;
	logic [1:0]     eff_open;
	logic           is_open;
	logic           eff_vis;
	logic           sel;
	logic [1:0]     left_dir;
	logic [1:0]     right_dir;
	logic [3:0]     ad_r;
	logic [3:0]     ad_c;
	logic [7:0]     sq_r;
	logic [7:0]     sq_c;
	logic [8:0]     sq_dist;
	logic           take;
	logic           open_we;
	logic [1:0]     open_wd;
	logic           vis_we;
	logic [7:0]     vis_wa;
	logic           req_fire;
	logic           cfg_wr;

	// Scan order: south, west, east, north
	function automatic logic [1:0] scan_dir(input logic [1:0] k);
		logic [1:0] d;
		unique case (k)
			2'd0: d = gmwm_pkg::DIR_S;
			2'd1: d = gmwm_pkg::DIR_W;
			2'd2: d = gmwm_pkg::DIR_E;
			default: d = gmwm_pkg::DIR_N;
		endcase
		return d;
	endfunction

	// Find the entry and bit of the passage leaving (r,c) toward d
	function automatic gmwm_pkg::loc_t locate(input logic [3:0] r, input logic [3:0] c,
			input logic [1:0] d, input logic [4:0] s);
		gmwm_pkg::loc_t l;
		logic in_grid;
		in_grid = ({1'b0, r} < s) && ({1'b0, c} < s);
		l.ok   = 1'b0;
		l.addr = {r, c};
		l.east = 1'b0;
		l.nbr  = {r, c};
		unique case (d)
			gmwm_pkg::DIR_N: begin
				l.ok  = in_grid && (({1'b0, r} + 5'd1) < s);
				l.nbr = {r + 4'd1, c};
			end
			gmwm_pkg::DIR_E: begin
				l.ok   = in_grid && (({1'b0, c} + 5'd1) < s);
				l.east = 1'b1;
				l.nbr  = {r, c + 4'd1};
			end
			gmwm_pkg::DIR_S: begin
				l.ok   = in_grid && (r != 4'd0);
				l.addr = {r - 4'd1, c};
				l.nbr  = {r - 4'd1, c};
			end
			default: begin
				l.ok   = in_grid && (c != 4'd0);
				l.addr = {r, c - 4'd1};
				l.east = 1'b1;
				l.nbr  = {r, c - 4'd1};
			end
		endcase
		return l;
	endfunction

	assign side = (grid_size_q > gmwm_pkg::GRID_SIDE) ? gmwm_pkg::GRID_SIDE : grid_size_q;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_size_q <= gmwm_pkg::GRID_SIZE_RST;
			goal_x_q    <= gmwm_pkg::GOAL_X_RST;
			goal_y_q    <= gmwm_pkg::GOAL_Y_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				gmwm_pkg::REG_GRID_SIZE: grid_size_q <= pwdata[4:0];
				gmwm_pkg::REG_GOAL_X:    goal_x_q    <= pwdata[3:0];
				gmwm_pkg::REG_GOAL_Y:    goal_y_q    <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			gmwm_pkg::REG_GRID_SIZE: prdata = {27'd0, grid_size_q};
			gmwm_pkg::REG_GOAL_X:    prdata = {28'd0, goal_x_q};
			gmwm_pkg::REG_GOAL_Y:    prdata = {28'd0, goal_y_q};
			default:                 prdata = 32'd0;
		endcase
	end

	// Handshakes
	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign out_free  = !rsp_vld_q || rsp.ready;

	// Pick the next passage to read: first one on accept, then advance
	always_comb begin
		if (state_q == ST_IDLE) begin
			rd_row = req.cell_req[7:4];
			rd_col = req.cell_req[3:0];
			rd_k   = 2'd0;
		end else begin
			rd_row = row_q;
			rd_col = col_q;
			rd_k   = k_q + 2'd1;
		end
		rd_loc = locate(rd_row, rd_col, scan_dir(rd_k), side);
	end

	// Evaluate the passage whose entries arrived this cycle
	always_comb begin
		cur_dir   = scan_dir(k_q);
		cur       = locate(row_q, col_q, cur_dir, side);
		left_dir  = hd_q + 2'd3;
		right_dir = hd_q + 2'd1;
		if (fwd_hit_s1) begin
			eff_open = fwd_data_s1;
		end else begin
			eff_open = open_rd_s1;
		end
		is_open = cur.ok && (cur.east ? eff_open[1] : eff_open[0]);
		eff_vis = vis_rd_s1;
		sel = (wl_q && (cur_dir == left_dir)) || (wf_q && (cur_dir == hd_q))
			|| (wr_q && (cur_dir == right_dir));

		ad_r = (cur.nbr[7:4] >= goal_x_q) ? (cur.nbr[7:4] - goal_x_q)
			: (goal_x_q - cur.nbr[7:4]);
		ad_c = (cur.nbr[3:0] >= goal_y_q) ? (cur.nbr[3:0] - goal_y_q)
			: (goal_y_q - cur.nbr[3:0]);
		sq_r = {4'd0, ad_r} * {4'd0, ad_r};
		sq_c = {4'd0, ad_c} * {4'd0, ad_c};
		sq_dist = {1'b0, sq_r} + {1'b0, sq_c};

		open_we = 1'b0;
		open_wd = eff_open & (cur.east ? 2'b01 : 2'b10);
		take    = 1'b0;
		chg_d   = chg_q;
		fnd_d   = fnd_q;
		best_d  = best_q;
		nxt_d   = nxt_q;
		if (state_q == ST_RUN) begin
			if (op_q == gmwm_pkg::OP_WALL) begin
				open_we = sel && is_open;
				chg_d   = chg_q || open_we;
			end else begin
				take = is_open && !eff_vis && (!fnd_q || (sq_dist < best_q));
				if (take) begin
					fnd_d  = 1'b1;
					best_d = sq_dist;
					nxt_d  = cur.nbr;
				end
			end
		end
	end

	// Hand over the result and mark the chosen cell
	always_comb begin
		rsp_load  = 1'b0;
		rsp_chg_n = chg_d;
		rsp_fnd_n = fnd_d;
		rsp_nxt_n = nxt_d;
		if (state_q == ST_RUN) begin
			rsp_load = (k_q == 2'd3) && out_free;
		end else if (state_q == ST_DONE) begin
			rsp_load  = out_free;
			rsp_chg_n = chg_q;
			rsp_fnd_n = fnd_q;
			rsp_nxt_n = nxt_q;
		end
		vis_we = rsp_load && (op_q == gmwm_pkg::OP_STEP) && rsp_fnd_n;
		vis_wa = rsp_nxt_n;
	end

	// Sequencer: clear the memories after reset, then serve requests
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			clr_q   <= 8'd0;
			k_q     <= 2'd0;
		end else begin
			unique case (state_q)
				ST_INIT: begin
					clr_q <= clr_q + 8'd1;
					if (clr_q == 8'hff) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_fire) begin
						state_q <= ST_RUN;
						k_q     <= 2'd0;
					end
				end
				ST_RUN: begin
					k_q <= k_q + 2'd1;
					if (k_q == 2'd3) begin
						state_q <= rsp_load ? ST_IDLE : ST_DONE;
					end
				end
				ST_DONE: begin
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold the request and the running result
	always_ff @(posedge clk) begin
		if (req_fire) begin
			op_q   <= req.operation;
			row_q  <= req.cell_req[7:4];
			col_q  <= req.cell_req[3:0];
			hd_q   <= req.heading;
			wl_q   <= req.seen_left;
			wf_q   <= req.seen_front;
			wr_q   <= req.seen_right;
			chg_q  <= 1'b0;
			fnd_q  <= 1'b0;
			best_q <= 9'd0;
			nxt_q  <= 8'd0;
		end else if (state_q == ST_RUN) begin
			chg_q  <= chg_d;
			fnd_q  <= fnd_d;
			best_q <= best_d;
			nxt_q  <= nxt_d;
		end
	end

	// Response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_chg_q <= rsp_chg_n;
			rsp_fnd_q <= rsp_fnd_n;
			rsp_nxt_q <= rsp_nxt_n;
		end
	end

	assign rsp.valid     = rsp_vld_q;
	assign rsp.changed   = rsp_chg_q;
	assign rsp.found     = rsp_fnd_q;
	assign rsp.next_cell = rsp_nxt_q;

	// Memories: clear or write, registered read, forward a write to the same entry
	always_ff @(posedge clk) begin
		if (state_q == ST_INIT) begin
			open_mem[clr_q] <= gmwm_pkg::PASSAGE_RST;
			vis_mem[clr_q]  <= 1'b0;
		end else begin
			if (open_we) begin
				open_mem[cur.addr] <= open_wd;
			end
			if (vis_we) begin
				vis_mem[vis_wa] <= 1'b1;
			end
		end
		open_rd_s1  <= open_mem[rd_loc.addr];
		vis_rd_s1   <= vis_mem[rd_loc.nbr];
		fwd_hit_s1  <= open_we && (cur.addr == rd_loc.addr);
		fwd_data_s1 <= open_wd;
	end

endmodule

@@ src/gmwm_checker.sv @@
`timescale 1ns / 1ps

module gmwm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic       rsp_changed,
	input logic       rsp_found,
	input logic [7:0] rsp_next_cell
);

	// A stalled result beat holds its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid
			&& $stable({rsp_changed, rsp_found, rsp_next_cell}))
		else $error("result beat changed while stalled");

	// A wall report never finds a cell and a step never closes a passage
	a_rsp_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp_changed && rsp_found))
		else $error("result beat has both changed and found");

	// No neighbour found means a zero cell
	a_rsp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_found |-> rsp_next_cell == 8'd0)
		else $error("next cell not zero without a find");

	// The scan keeps the request side closed after a beat is taken
	a_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken during a scan");

	// No result can appear in the cycle after an accept
	a_rsp_lat: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && !rsp_valid |=> !rsp_valid)
		else $error("result beat appeared too early");

endmodule

bind grid_maze_wall_map_greedy_step gmwm_checker u_gmwm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_changed   (rsp.changed),
	.rsp_found     (rsp.found),
	.rsp_next_cell (rsp.next_cell)
);
